// File: sv/pkte_pkg.sv
// pkte_pkg: transfer types, opcodes, key codes and letter tables for the
// predictive keypad text entry block. No dependencies.
package pkte_pkg;

  // field widths fixed by the item format
  localparam int LEN_W  = 5;
  localparam int FREQ_W = 16;
  localparam int CHAR_W = 8;

  // default sizes handed to the top level
  localparam int DICT_WORDS_DEF = 1024;
  localparam int WORD_CHARS_DEF = 20;

  // opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd7;
  localparam logic [3:0] KEY_ONE        = 4'd8;
  localparam logic [3:0] KEY_SPACE      = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;

  localparam int              PUNCT_COUNT = 3;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 5'd31;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CHAR_W-1:0] dict_char;
    logic [FREQ_W-1:0] start_frequency;
    logic [3:0]        key_code;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;
  } out_t;

  // letter lies on digit key (digit index 0 means key 2)
  function automatic logic key_hit(input logic [2:0] key, input logic [CHAR_W-1:0] c);
    logic r;
    case (key)
      3'd0:    r = c inside {8'h61, 8'h62, 8'h63};
      3'd1:    r = c inside {8'h64, 8'h65, 8'h66};
      3'd2:    r = c inside {8'h67, 8'h68, 8'h69};
      3'd3:    r = c inside {8'h6a, 8'h6b, 8'h6c};
      3'd4:    r = c inside {8'h6d, 8'h6e, 8'h6f};
      3'd5:    r = c inside {[8'h70:8'h73]};
      3'd6:    r = c inside {8'h74, 8'h75, 8'h76};
      default: r = c inside {[8'h77:8'h7a]};
    endcase
    return r;
  endfunction

  // punctuation choice by rank
  function automatic logic [CHAR_W-1:0] punct_char(input logic [1:0] rank);
    logic [CHAR_W-1:0] r;
    case (rank)
      2'd0:    r = 8'h2e;
      2'd1:    r = 8'h2c;
      default: r = 8'h3f;
    endcase
    return r;
  endfunction

endpackage

// File: sv/predictive_keypad_text_entry.sv
// predictive_keypad_text_entry: keypad text entry with dictionary ranking.
// Depends on pkte_pkg for transfer types, codes and letter tables.
//
// Usage: load the dictionary with load-char items (opcode 0) and close each
// word with its starting frequency (opcode 1). Then send keypad items
// (opcode 2) and a final flush (opcode 3). Each item is one input transfer
// (in_valid high, in_stall low); results come out one character per output
// transfer, the last one of an item flagged by last_of_run.
// Load and close items are taken back to back. A digit key runs a filter
// sweep over the word store; an ending key or flush runs a length sweep,
// then a commit of (rank+1) selection passes, the letters, the frequency
// update and the end of the item.
// The sweeps read the words one after another through the registered memory
// ports; one pair of ranking comparators is shared by every selection pass.
// in_stall stays high until an item is finished. A character is held back
// until the next one or the end of the item so its last_of_run flag is known;
// when out_stall is high the block waits with the character in its output
// register. After reset the dictionary is empty and nothing is pending; the
// word store needs no clearing pass since only loaded words are ever read.
module predictive_keypad_text_entry #(
  parameter int DICT_WORDS = pkte_pkg::DICT_WORDS_DEF,
  parameter int WORD_CHARS = pkte_pkg::WORD_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pkte_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pkte_pkg::out_t out_data
);

  localparam int LEN_W  = pkte_pkg::LEN_W;
  localparam int FREQ_W = pkte_pkg::FREQ_W;
  localparam int CHAR_W = pkte_pkg::CHAR_W;
  localparam int AW     = $clog2(DICT_WORDS);
  localparam int SW     = $clog2(DICT_WORDS + 1);
  localparam int LDEPTH = DICT_WORDS * WORD_CHARS;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int LBW    = $clog2(LDEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RANK   = 12'b0000_0000_0010,
    S_KEY    = 12'b0000_0000_0100,
    S_COMMIT = 12'b0000_0000_1000,
    S_SEL    = 12'b0000_0001_0000,
    S_EMITW  = 12'b0000_0010_0000,
    S_EMITD  = 12'b0000_0100_0000,
    S_UPD    = 12'b0000_1000_0000,
    S_POST   = 12'b0001_0000_0000,
    S_FILT   = 12'b0010_0000_0000,
    S_PUSH   = 12'b0100_0000_0000,
    S_FLUSH  = 12'b1000_0000_0000
  } state_t;

  // word store
  logic [CHAR_W-1:0] let_mem  [LDEPTH];
  logic [LEN_W-1:0]  len_mem  [DICT_WORDS];
  logic [FREQ_W-1:0] freq_mem [DICT_WORDS];
  logic [FREQ_W-1:0] lu_mem   [DICT_WORDS];
  logic              cand_mem [DICT_WORDS];

  logic [CHAR_W-1:0] let_q;
  logic [LEN_W-1:0]  len_q;
  logic [FREQ_W-1:0] freq_q, lu_q;
  logic              cand_q;

  // sequencer and block state
  state_t state_r, state_nxt, push_ret_r, push_ret_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [3:0]        key_r, key_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LBW-1:0]    wbase_r, wbase_nxt;
  logic [LEN_W-1:0]  typed_r, typed_nxt;
  logic              typing_r, typing_nxt;
  logic              punct_r, punct_nxt;
  logic              pending_r, pending_nxt;
  logic [SW-1:0]     rank_r, rank_nxt;
  logic [SW-1:0]     total_r, total_nxt;
  logic [FREQ_W-1:0] useq_r, useq_nxt;
  logic              fresh_r, fresh_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic              ph_r, ph_nxt;
  logic [LBW-1:0]    lbase_r, lbase_nxt;
  logic [SW-1:0]     pass_r, pass_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic [AW-1:0]     prev_idx_r, prev_idx_nxt;
  logic [FREQ_W-1:0] prev_freq_r, prev_freq_nxt, prev_lu_r, prev_lu_nxt;
  logic              best_valid_r, best_valid_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [FREQ_W-1:0] best_freq_r, best_freq_nxt, best_lu_r, best_lu_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [LBW-1:0]    best_base_r, best_base_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  logic [CHAR_W-1:0] hold_char_r, hold_char_nxt, push_char_r, push_char_nxt;
  logic              out_valid_r, out_valid_nxt;
  pkte_pkg::out_t    out_data_r, out_data_nxt;

  // memory port controls
  logic              let_we, len_we, freq_we, lu_we, cand_we;
  logic [AW-1:0]     w_idx, r_idx;
  logic [LAW-1:0]    let_waddr, let_raddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [FREQ_W-1:0] freq_wdata, lu_wdata;
  logic              cand_wdata;
  logic [LBW-1:0]    load_sum, filt_sum, emit_sum;
  logic              slot_free, take, keep, hit, typed_in;
  logic [SW-1:0]     rank_inc;

  // ranking comparator: does word a rank before word b
  function automatic logic ranks_before(
    input logic [FREQ_W-1:0] fa, input logic [FREQ_W-1:0] la, input logic [AW-1:0] ia,
    input logic [FREQ_W-1:0] fb, input logic [FREQ_W-1:0] lb, input logic [AW-1:0] ib);
    logic r;
    if (fa != fb) begin
      r = fa > fb;
    end else if (la != lb) begin
      r = la > lb;
    end else begin
      r = ia < ib;
    end
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign load_sum  = wbase_r + LBW'(pos_r);
  assign typed_in  = typed_r < LEN_W'(WORD_CHARS);
  assign filt_sum  = lbase_r + (typed_in ? LBW'(typed_r) : '0);
  assign emit_sum  = best_base_r + LBW'(k_r);
  assign let_waddr = load_sum[LAW-1:0];
  assign let_raddr = (state_r == S_EMITW) ? emit_sum[LAW-1:0] : filt_sum[LAW-1:0];
  assign r_idx     = idx_r[AW-1:0];
  assign slot_free = !out_valid_r || !out_stall;
  assign rank_inc  = rank_r + SW'(1);

  // per-word decisions of the sweeps
  assign keep = cand_q && (len_q == typed_r);
  assign hit  = (fresh_r || cand_q) && (typed_r < len_q) && typed_in &&
                pkte_pkg::key_hit(key_r[2:0], let_q);
  assign take = cand_q &&
                (!prev_valid_r || ranks_before(prev_freq_r, prev_lu_r, prev_idx_r,
                                               freq_q, lu_q, idx_r[AW-1:0])) &&
                (!best_valid_r || ranks_before(freq_q, lu_q, idx_r[AW-1:0],
                                               best_freq_r, best_lu_r, best_idx_r));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    push_ret_nxt   = push_ret_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    pos_nxt        = pos_r;
    wbase_nxt      = wbase_r;
    typed_nxt      = typed_r;
    typing_nxt     = typing_r;
    punct_nxt      = punct_r;
    pending_nxt    = pending_r;
    rank_nxt       = rank_r;
    total_nxt      = total_r;
    useq_nxt       = useq_r;
    fresh_nxt      = fresh_r;
    idx_nxt        = idx_r;
    ph_nxt         = ph_r;
    lbase_nxt      = lbase_r;
    pass_nxt       = pass_r;
    prev_valid_nxt = prev_valid_r;
    prev_idx_nxt   = prev_idx_r;
    prev_freq_nxt  = prev_freq_r;
    prev_lu_nxt    = prev_lu_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_freq_nxt  = best_freq_r;
    best_lu_nxt    = best_lu_r;
    best_len_nxt   = best_len_r;
    best_base_nxt  = best_base_r;
    k_nxt          = k_r;
    hold_valid_nxt = hold_valid_r;
    hold_char_nxt  = hold_char_r;
    push_char_nxt  = push_char_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    let_we         = 1'b0;
    len_we         = 1'b0;
    freq_we        = 1'b0;
    lu_we          = 1'b0;
    cand_we        = 1'b0;
    w_idx          = idx_r[AW-1:0];
    len_wdata      = pos_r;
    freq_wdata     = in_data.start_frequency;
    lu_wdata       = '0;
    cand_wdata     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          key_nxt = in_data.key_code;
          case (in_data.opcode)
            pkte_pkg::OP_LOAD: begin
              if (size_r < SW'(DICT_WORDS) && pos_r < LEN_W'(WORD_CHARS)) begin
                let_we  = 1'b1;
                pos_nxt = pos_r + LEN_W'(1);
              end
            end
            pkte_pkg::OP_CLOSE: begin
              if (size_r < SW'(DICT_WORDS)) begin
                w_idx     = size_r[AW-1:0];
                len_we    = 1'b1;
                freq_we   = 1'b1;
                lu_we     = 1'b1;
                cand_we   = 1'b1;
                size_nxt  = size_r + SW'(1);
                wbase_nxt = wbase_r + LBW'(WORD_CHARS);
              end
              pos_nxt = '0;
            end
            default: begin
              idx_nxt   = '0;
              ph_nxt    = 1'b0;
              lbase_nxt = '0;
              if (in_data.opcode == pkte_pkg::OP_KEY &&
                  in_data.key_code <= pkte_pkg::KEY_LAST_DIGIT) begin
                state_nxt = typing_r ? S_FILT : S_COMMIT;
              end else if (typing_r) begin
                total_nxt = '0;
                state_nxt = S_RANK;
              end else begin
                state_nxt = S_KEY;
              end
            end
          endcase
        end
      end

      // drop candidates of the wrong length and count the rest
      S_RANK: begin
        if (!ph_r) begin
          if (idx_r == size_r) begin
            if (total_r != '0) begin
              pending_nxt = 1'b1;
              rank_nxt    = '0;
            end
            typing_nxt = 1'b0;
            state_nxt  = S_KEY;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          cand_we    = 1'b1;
          cand_wdata = keep;
          total_nxt  = total_r + SW'(keep);
          idx_nxt    = idx_r + SW'(1);
          ph_nxt     = 1'b0;
        end
      end

      // action of a non-digit key or flush
      S_KEY: begin
        if (op_r == pkte_pkg::OP_FLUSH || key_r == pkte_pkg::KEY_ONE ||
            key_r == pkte_pkg::KEY_SPACE) begin
          state_nxt = S_COMMIT;
        end else begin
          if (key_r == pkte_pkg::KEY_STAR && pending_r) begin
            rank_nxt = (rank_inc >= total_r) ? '0 : rank_inc;
          end
          state_nxt = S_FLUSH;
        end
      end

      S_COMMIT: begin
        if (!pending_r) begin
          state_nxt = S_POST;
        end else if (punct_r) begin
          if (rank_r < SW'(pkte_pkg::PUNCT_COUNT)) begin
            push_char_nxt = pkte_pkg::punct_char(rank_r[1:0]);
            push_ret_nxt  = S_POST;
            state_nxt     = S_PUSH;
          end else begin
            state_nxt = S_POST;
          end
          punct_nxt   = 1'b0;
          pending_nxt = 1'b0;
        end else begin
          pass_nxt       = '0;
          prev_valid_nxt = 1'b0;
          best_valid_nxt = 1'b0;
          idx_nxt        = '0;
          ph_nxt         = 1'b0;
          lbase_nxt      = '0;
          state_nxt      = S_SEL;
        end
      end

      // one pass finds the best candidate ranked after the previous pick
      S_SEL: begin
        if (!ph_r) begin
          if (idx_r == size_r) begin
            if (pass_r == rank_r) begin
              k_nxt     = '0;
              state_nxt = S_EMITW;
            end else begin
              prev_valid_nxt = best_valid_r;
              prev_idx_nxt   = best_idx_r;
              prev_freq_nxt  = best_freq_r;
              prev_lu_nxt    = best_lu_r;
              best_valid_nxt = 1'b0;
              pass_nxt       = pass_r + SW'(1);
              idx_nxt        = '0;
              lbase_nxt      = '0;
            end
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          if (take) begin
            best_valid_nxt = 1'b1;
            best_idx_nxt   = idx_r[AW-1:0];
            best_freq_nxt  = freq_q;
            best_lu_nxt    = lu_q;
            best_len_nxt   = len_q;
            best_base_nxt  = lbase_r;
          end
          idx_nxt   = idx_r + SW'(1);
          lbase_nxt = lbase_r + LBW'(WORD_CHARS);
          ph_nxt    = 1'b0;
        end
      end

      S_EMITW: begin
        if (k_r < best_len_r && k_r < LEN_W'(WORD_CHARS)) begin
          state_nxt = S_EMITD;
        end else begin
          state_nxt = S_UPD;
        end
      end

      S_EMITD: begin
        push_char_nxt = let_q;
        push_ret_nxt  = S_EMITW;
        k_nxt         = k_r + LEN_W'(1);
        state_nxt     = S_PUSH;
      end

      // frequency and last use of the committed word
      S_UPD: begin
        w_idx       = best_idx_r;
        freq_we     = 1'b1;
        freq_wdata  = (best_freq_r == '1) ? best_freq_r : best_freq_r + FREQ_W'(1);
        lu_we       = 1'b1;
        lu_wdata    = useq_r;
        useq_nxt    = (useq_r == '1) ? useq_r : useq_r + FREQ_W'(1);
        total_nxt   = '0;
        pending_nxt = 1'b0;
        state_nxt   = S_POST;
      end

      // follow-up after a commit
      S_POST: begin
        if (op_r == pkte_pkg::OP_KEY && key_r <= pkte_pkg::KEY_LAST_DIGIT) begin
          typing_nxt = 1'b1;
          typed_nxt  = '0;
          fresh_nxt  = 1'b1;
          idx_nxt    = '0;
          ph_nxt     = 1'b0;
          lbase_nxt  = '0;
          state_nxt  = S_FILT;
        end else if (op_r == pkte_pkg::OP_KEY && key_r == pkte_pkg::KEY_ONE) begin
          punct_nxt   = 1'b1;
          pending_nxt = 1'b1;
          rank_nxt    = '0;
          total_nxt   = SW'(pkte_pkg::PUNCT_COUNT);
          state_nxt   = S_FLUSH;
        end else if (op_r == pkte_pkg::OP_KEY && key_r == pkte_pkg::KEY_SPACE) begin
          push_char_nxt = pkte_pkg::CHAR_SPACE;
          push_ret_nxt  = S_FLUSH;
          state_nxt     = S_PUSH;
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      // narrow candidates by the letter at the typed position
      S_FILT: begin
        if (!ph_r) begin
          if (idx_r == size_r) begin
            typed_nxt = (typed_r == pkte_pkg::LEN_MAX) ? typed_r : typed_r + LEN_W'(1);
            fresh_nxt = 1'b0;
            state_nxt = S_FLUSH;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          cand_we    = 1'b1;
          cand_wdata = hit;
          idx_nxt    = idx_r + SW'(1);
          lbase_nxt  = lbase_r + LBW'(WORD_CHARS);
          ph_nxt     = 1'b0;
        end
      end

      // a new character pushes the held one out with last_of_run clear
      S_PUSH: begin
        if (!hold_valid_r || slot_free) begin
          if (hold_valid_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.out_char    = hold_char_r;
            out_data_nxt.last_of_run = 1'b0;
          end
          hold_char_nxt  = push_char_r;
          hold_valid_nxt = 1'b1;
          state_nxt      = push_ret_r;
        end
      end

      // end of item: the held character goes out as the last one
      S_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_char    = hold_char_r;
          out_data_nxt.last_of_run = 1'b1;
          hold_valid_nxt           = 1'b0;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // letter memory
  always_ff @(posedge clk) begin
    if (let_we) begin
      let_mem[let_waddr] <= in_data.dict_char;
    end
    let_q <= let_mem[let_raddr];
  end

  // per-word memories
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[w_idx] <= len_wdata;
    end
    if (freq_we) begin
      freq_mem[w_idx] <= freq_wdata;
    end
    if (lu_we) begin
      lu_mem[w_idx] <= lu_wdata;
    end
    if (cand_we) begin
      cand_mem[w_idx] <= cand_wdata;
    end
    len_q  <= len_mem[r_idx];
    freq_q <= freq_mem[r_idx];
    lu_q   <= lu_mem[r_idx];
    cand_q <= cand_mem[r_idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      size_r       <= '0;
      pos_r        <= '0;
      wbase_r      <= '0;
      typed_r      <= '0;
      typing_r     <= 1'b0;
      punct_r      <= 1'b0;
      pending_r    <= 1'b0;
      rank_r       <= '0;
      total_r      <= '0;
      useq_r       <= FREQ_W'(1);
      fresh_r      <= 1'b0;
      ph_r         <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      size_r       <= size_nxt;
      pos_r        <= pos_nxt;
      wbase_r      <= wbase_nxt;
      typed_r      <= typed_nxt;
      typing_r     <= typing_nxt;
      punct_r      <= punct_nxt;
      pending_r    <= pending_nxt;
      rank_r       <= rank_nxt;
      total_r      <= total_nxt;
      useq_r       <= useq_nxt;
      fresh_r      <= fresh_nxt;
      ph_r         <= ph_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers and payload
  always_ff @(posedge clk) begin
    push_ret_r   <= push_ret_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    lbase_r      <= lbase_nxt;
    pass_r       <= pass_nxt;
    prev_valid_r <= prev_valid_nxt;
    prev_idx_r   <= prev_idx_nxt;
    prev_freq_r  <= prev_freq_nxt;
    prev_lu_r    <= prev_lu_nxt;
    best_valid_r <= best_valid_nxt;
    best_idx_r   <= best_idx_nxt;
    best_freq_r  <= best_freq_nxt;
    best_lu_r    <= best_lu_nxt;
    best_len_r   <= best_len_nxt;
    best_base_r  <= best_base_nxt;
    k_r          <= k_nxt;
    hold_char_r  <= hold_char_nxt;
    push_char_r  <= push_char_nxt;
    out_data_r   <= out_data_nxt;
  end

  // every item leaves nothing held back once idle
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_valid_r)
    else $error("character still held while idle");

  // a pending choice always has a valid rank
  a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> rank_r < total_r)
    else $error("choice rank beyond candidate total");

  // no choice is pending while a word is being typed
  a_typing_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    typing_r |-> !pending_r)
    else $error("choice pending during typing");

  // output is loaded only from the push or end-of-item steps
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUSH || $past(state_r) == S_FLUSH))
    else $error("output loaded from an unexpected step");

endmodule

// File: test/tb_predictive_keypad_text_entry.sv
// tb_predictive_keypad_text_entry: self-checking bench for the keypad text entry block,
// with a cycle-level driver, output monitor and a behavioural predictor of the word store.
// Depends on pkte_pkg and predictive_keypad_text_entry.
`timescale 1ns / 1ps

module tb_predictive_keypad_text_entry;

  localparam int NWORDS = pkte_pkg::DICT_WORDS_DEF;
  localparam int NCHARS = pkte_pkg::WORD_CHARS_DEF;
  localparam int GEN_KEEP = 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int KEY_OTHER = 11;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pkte_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  pkte_pkg::out_t out_data;

  predictive_keypad_text_entry u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state for the word store and typing session
  logic [7:0] word_char [NWORDS][NCHARS];
  int  word_len  [NWORDS];
  int  word_freq [NWORDS];
  int  word_used [NWORDS];
  bit  word_live [NWORDS];
  int  dict_count;
  int  load_pos;
  int  typed_count;
  bit  typing;
  bit  punct_on;
  bit  choice_open;
  int  choice_idx;
  int  choice_total;
  int  use_stamp;

  pkte_pkg::in_t  key_items [$];
  pkte_pkg::out_t expected_chars [$];
  int   n_accepted;
  int   n_mismatch;
  int   out_hold;
  bit   hold_done;

  // generator side copy of words for typing them back
  logic [7:0] gen_char [GEN_KEEP][32];
  int  gen_len [GEN_KEEP];
  int  gen_words;
  int  gen_dict;

  // keypad digit index of a letter, -1 when on no key
  function automatic int letter_digit(input logic [7:0] c);
    if (c >= "a" && c <= "c") return 0;
    if (c >= "d" && c <= "f") return 1;
    if (c >= "g" && c <= "i") return 2;
    if (c >= "j" && c <= "l") return 3;
    if (c >= "m" && c <= "o") return 4;
    if (c >= "p" && c <= "s") return 5;
    if (c >= "t" && c <= "v") return 6;
    if (c >= "w" && c <= "z") return 7;
    return -1;
  endfunction

  function automatic bit outranks(input int j, input int i);
    if (word_freq[j] != word_freq[i]) return word_freq[j] > word_freq[i];
    if (word_used[j] != word_used[i]) return word_used[j] > word_used[i];
    return j < i;
  endfunction

  task automatic emit_char(ref pkte_pkg::out_t res[$], input logic [7:0] c);
    pkte_pkg::out_t o;
    o.out_char = c;
    o.last_of_run = 1'b0;
    res.push_back(o);
  endtask

  // end of typed word: keep words of the typed length
  task automatic close_typing();
    if (!typing) return;
    choice_total = 0;
    for (int i = 0; i < dict_count; i++) begin
      if (word_live[i] && word_len[i] == typed_count) choice_total++;
      else word_live[i] = 0;
    end
    if (choice_total > 0) begin
      choice_open = 1;
      choice_idx = 0;
    end
  endtask

  task automatic commit_choice(ref pkte_pkg::out_t res[$]);
    int r;
    if (!choice_open) return;
    if (punct_on) begin
      if (choice_idx == 0) emit_char(res, ".");
      else if (choice_idx == 1) emit_char(res, ",");
      else if (choice_idx == 2) emit_char(res, "?");
      punct_on = 0;
    end else begin
      for (int i = 0; i < dict_count; i++) begin
        if (!word_live[i]) continue;
        r = 0;
        for (int j = 0; j < dict_count; j++)
          if (j != i && word_live[j] && outranks(j, i)) r++;
        if (r != choice_idx) continue;
        for (int k = 0; k < word_len[i]; k++) emit_char(res, word_char[i][k]);
        if (word_freq[i] < 65535) word_freq[i]++;
        word_used[i] = use_stamp;
        if (use_stamp < 65535) use_stamp++;
        break;
      end
      choice_total = 0;
    end
    choice_open = 0;
  endtask

  task automatic filter_digit(input int d, ref pkte_pkg::out_t res[$]);
    logic [7:0] c;
    bit hit;
    if (!typing) begin
      commit_choice(res);
      typing = 1;
      typed_count = 0;
      for (int i = 0; i < dict_count; i++) word_live[i] = 1;
    end
    for (int i = 0; i < dict_count; i++) begin
      if (!word_live[i]) continue;
      hit = 0;
      if (typed_count < word_len[i] && typed_count < NCHARS) begin
        c = word_char[i][typed_count];
        hit = (letter_digit(c) == d);
      end
      word_live[i] = hit;
    end
    if (typed_count < 31) typed_count++;
  endtask

  // expected characters for one accepted item
  task automatic predict_item(input pkte_pkg::in_t it);
    pkte_pkg::out_t res[$];
    if (it.opcode == pkte_pkg::OP_LOAD) begin
      if (dict_count < NWORDS && load_pos < NCHARS) begin
        word_char[dict_count][load_pos] = it.dict_char;
        load_pos++;
      end
    end else if (it.opcode == pkte_pkg::OP_CLOSE) begin
      if (dict_count < NWORDS) begin
        word_len[dict_count] = load_pos;
        word_freq[dict_count] = it.start_frequency;
        word_used[dict_count] = 0;
        word_live[dict_count] = 0;
        dict_count++;
      end
      load_pos = 0;
    end else if (it.opcode == pkte_pkg::OP_KEY) begin
      if (it.key_code <= pkte_pkg::KEY_LAST_DIGIT) begin
        filter_digit(int'(it.key_code), res);
      end else begin
        close_typing();
        typing = 0;
        if (it.key_code == pkte_pkg::KEY_ONE) begin
          commit_choice(res);
          punct_on = 1;
          choice_open = 1;
          choice_idx = 0;
          choice_total = pkte_pkg::PUNCT_COUNT;
        end else if (it.key_code == pkte_pkg::KEY_SPACE) begin
          commit_choice(res);
          emit_char(res, pkte_pkg::CHAR_SPACE);
        end else if (it.key_code == pkte_pkg::KEY_STAR) begin
          if (choice_open) begin
            choice_idx++;
            if (choice_idx >= choice_total) choice_idx = 0;
          end
        end
      end
    end else begin
      close_typing();
      typing = 0;
      commit_choice(res);
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[k]) expected_chars.push_back(res[k]);
  endtask

  // stimulus helpers
  task automatic push_raw(input logic [1:0] op, input logic [7:0] c, input logic [15:0] f,
                          input logic [3:0] k);
    pkte_pkg::in_t it;
    it.opcode = op;
    it.dict_char = c;
    it.start_frequency = f;
    it.key_code = k;
    key_items.push_back(it);
  endtask

  task automatic push_key(input int k);
    push_raw(pkte_pkg::OP_KEY, 8'($urandom), 16'($urandom), 4'(k));
  endtask

  task automatic load_word(input logic [7:0] chars[$], input int f);
    foreach (chars[k]) push_raw(pkte_pkg::OP_LOAD, chars[k], 16'($urandom), 4'($urandom));
    push_raw(pkte_pkg::OP_CLOSE, 8'($urandom), 16'(f), 4'($urandom));
    if (gen_words < GEN_KEEP && gen_dict < NWORDS) begin
      gen_len[gen_words] = (chars.size() > NCHARS) ? NCHARS : chars.size();
      for (int k = 0; k < gen_len[gen_words]; k++) gen_char[gen_words][k] = chars[k];
      gen_words++;
    end
    gen_dict++;
  endtask

  task automatic load_text(input string s, input int f);
    logic [7:0] chars[$];
    for (int k = 0; k < s.len(); k++) chars.push_back(s[k]);
    load_word(chars, f);
  endtask

  // digits of a stored word; letters on no key become random digits
  task automatic type_word(input int w);
    int d;
    for (int k = 0; k < gen_len[w]; k++) begin
      d = letter_digit(gen_char[w][k]);
      push_key(d < 0 ? $urandom_range(0, 7) : d);
    end
  endtask

  task automatic random_word();
    logic [7:0] chars[$];
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      chars.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7a)));
    load_word(chars, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8));
  endtask

  task automatic build_stimulus();
    logic [7:0] odd[$];
    int sel;
    // directed: ties, saturated frequency, long word, odd characters, empty word
    load_text("cat", 5);
    load_text("act", 5);
    load_text("bat", 5);
    load_text("home", 65535);
    load_text("good", 65535);
    load_text("abcdefghijklmnopqrstuvwx", 1);
    odd = '{8'h00, 8'hff, "a"};
    load_word(odd, 0);
    push_raw(pkte_pkg::OP_CLOSE, 8'hff, 16'h0000, 4'hf);
    type_word(0);
    push_key(pkte_pkg::KEY_STAR); push_key(pkte_pkg::KEY_STAR); push_key(pkte_pkg::KEY_STAR);
    push_key(pkte_pkg::KEY_SPACE);
    type_word(3);
    push_raw(pkte_pkg::OP_FLUSH, 8'h00, 16'hffff, 4'h0);
    push_key(pkte_pkg::KEY_ONE); push_key(pkte_pkg::KEY_STAR); push_key(pkte_pkg::KEY_STAR);
    push_key(pkte_pkg::KEY_SPACE);
    push_key(pkte_pkg::KEY_ONE); push_raw(pkte_pkg::OP_FLUSH, 8'hff, 16'h0000, 4'hf);
    push_key(KEY_OTHER); push_key(15); push_key(pkte_pkg::KEY_STAR);
    type_word(5);
    push_key(0); push_key(0);
    push_key(pkte_pkg::KEY_SPACE);
    type_word(1);
    push_key(pkte_pkg::KEY_ONE); push_key(pkte_pkg::KEY_STAR); push_key(pkte_pkg::KEY_SPACE);
    // random: mostly whole words typed back, some loads and noise
    while (key_items.size() < 410) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        type_word($urandom_range(0, gen_words - 1));
        repeat ($urandom_range(0, 3)) push_key(pkte_pkg::KEY_STAR);
        case ($urandom_range(0, 5))
          0, 1, 2: push_key(pkte_pkg::KEY_SPACE);
          3:       push_raw(pkte_pkg::OP_FLUSH, 8'($urandom), 16'($urandom), 4'($urandom));
          4:       push_key(pkte_pkg::KEY_ONE);
          default: push_key($urandom_range(KEY_OTHER, 15));
        endcase
      end else if (sel < 72) begin
        random_word();
      end else if (sel < 96) begin
        if ($urandom_range(0, 1) == 0) push_key($urandom_range(0, 15));
        else push_raw(pkte_pkg::OP_FLUSH, 8'($urandom), 16'($urandom), 4'($urandom));
      end else if (sel < 99) begin
        repeat ($urandom_range(1, 5)) push_key($urandom_range(0, 7));
      end else begin
        repeat (34) push_key($urandom_range(0, 7));
        push_key(pkte_pkg::KEY_SPACE);
      end
    end
    // a late load, then a last round of typing
    push_raw(pkte_pkg::OP_LOAD, "a", 16'($urandom), 4'($urandom));
    push_raw(pkte_pkg::OP_CLOSE, 8'($urandom), 16'hffff, 4'($urandom));
    type_word(0);
    push_key(pkte_pkg::KEY_STAR);
    push_key(pkte_pkg::KEY_SPACE);
    type_word(3);
    push_raw(pkte_pkg::OP_FLUSH, 8'($urandom), 16'($urandom), 4'($urandom));
  endtask

  function automatic int sender_idle_pct();
    if (n_accepted < 140) return 18;
    if (n_accepted < 280) return 50;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < 140) return 50;
    if (n_accepted < 280) return 18;
    return 0;
  endfunction

  // driver: predict on each accepted transfer, then offer the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (key_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_data <= key_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off early in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= 60) begin
      hold_done <= 1'b1;
      out_hold <= 4000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // monitor: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    pkte_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transfer: char %h last %b", out_data.out_char, out_data.last_of_run);
      end else begin
        want = expected_chars.pop_front();
        if (want.out_char !== out_data.out_char || want.last_of_run !== out_data.last_of_run) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.out_char, want.last_of_run, out_data.out_char, out_data.last_of_run);
        end
      end
    end
  end

  // run limit
  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cycles = 0;
    out_hold = 0;
    hold_done = 1'b0;
    n_accepted = 0;
    n_mismatch = 0;
    dict_count = 0;
    load_pos = 0;
    typed_count = 0;
    typing = 0;
    punct_on = 0;
    choice_open = 0;
    choice_idx = 0;
    choice_total = 0;
    use_stamp = 1;
    gen_words = 0;
    gen_dict = 0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (key_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (20000) @(posedge clk);
    if (n_mismatch == 0 && expected_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pkte_pkg.sv
sv/predictive_keypad_text_entry.sv
test/tb_predictive_keypad_text_entry.sv
